>>> rtl/txas_pkg.sv
// Shared types and constants for the touch X/Y averaging and scaling block.
// No dependencies; imported by txas_div and touch_xy_average_and_scale.
package txas_pkg;

  localparam int SMP_W = 12;
  localparam int CNT_W = 8;
  localparam int SUM_W = SMP_W + CNT_W;
  localparam int DVD_W = (2 * SMP_W > SUM_W) ? 2 * SMP_W : SUM_W;
  localparam int DVS_W = (SMP_W > CNT_W) ? SMP_W : CNT_W;
  localparam int STEP_W = $clog2(DVD_W);
  localparam int CFG_IDX_W = 3;

  localparam logic [CNT_W-1:0] NUM_AVG_RST = CNT_W'(64);
  localparam logic [SMP_W-1:0] LIM_LO_RST = SMP_W'(200);
  localparam logic [SMP_W-1:0] LIM_HI_RST = SMP_W'(3900);
  localparam logic [SMP_W-1:0] RES_X_RST = SMP_W'(320);
  localparam logic [SMP_W-1:0] RES_Y_RST = SMP_W'(240);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_AVG  = 3'd0,
    CFG_X_LIM_LO = 3'd1,
    CFG_X_LIM_HI = 3'd2,
    CFG_Y_LIM_LO = 3'd3,
    CFG_Y_LIM_HI = 3'd4,
    CFG_RES_X    = 3'd5,
    CFG_RES_Y    = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic [SMP_W-1:0] x_raw;
    logic [SMP_W-1:0] y_raw;
  } txas_in_t;

  typedef struct packed {
    logic [SMP_W-1:0] x_pos;
    logic [SMP_W-1:0] y_pos;
  } txas_out_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } txas_div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DVD_W-1:0] quotient;
  } txas_div_rsp_t;

endpackage

>>> rtl/txas_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on txas_pkg for widths and the request/response structs.
module txas_div
  import txas_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  txas_div_req_t req,
  output txas_div_rsp_t rsp
);

  logic [DVD_W-1:0]  quo_r;
  logic [DVS_W-1:0]  rem_r;
  logic [DVS_W-1:0]  dvs_r;
  logic [STEP_W-1:0] step_r;
  logic              busy_r;
  logic              done_r;
  logic [DVS_W:0]    shifted;
  logic [DVS_W:0]    trial;
  logic              fits;

  always_comb begin
    shifted = {rem_r, quo_r[DVD_W-1]};
    trial   = shifted - {1'b0, dvs_r};
    fits    = shifted >= {1'b0, dvs_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start && !busy_r) begin
        quo_r  <= req.dividend;
        rem_r  <= '0;
        dvs_r  <= req.divisor;
        step_r <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r  <= fits ? trial[DVS_W-1:0] : shifted[DVS_W-1:0];
        quo_r  <= {quo_r[DVD_W-2:0], fits};
        step_r <= step_r + STEP_W'(1);
        if (step_r == STEP_W'(DVD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

>>> rtl/touch_xy_average_and_scale.sv
// Touch X/Y averaging and scaling, top level: accumulators, config, sequencer.
// Depends on txas_pkg and txas_div.
//
// Each input beat adds one raw X/Y pair to the registered running sums, and
// the block is ready again on the next cycle. When the pair count reaches
// num_avg (0 counts as 1), the beat starts a computation during which
// in_ready is low: a single shared 1-bit-per-cycle divider runs four
// times (X mean, Y mean, X scale, Y scale), with a 12x12 multiply state
// before each scale division and an output state that loads the result.
// The load waits while the previous result is still held, which lengthens
// the busy time by that wait. The result sits in an output register, so
// accumulation goes on while it waits to be taken. cfg_ready is always high;
// write registers only while the block is idle.
module touch_xy_average_and_scale
  import txas_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  txas_in_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output txas_out_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SMP_W-1:0]     cfg_data
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MX,
    ST_MX_W,
    ST_MY,
    ST_MY_W,
    ST_MUL_X,
    ST_SX,
    ST_SX_W,
    ST_MUL_Y,
    ST_SY,
    ST_SY_W,
    ST_OUT
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] num_avg_r;
  logic [SMP_W-1:0] x_lo_r, x_hi_r, y_lo_r, y_hi_r, res_x_r, res_y_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [SUM_W-1:0] x_sum_r, x_sum_nxt, y_sum_r, y_sum_nxt;
  logic [SMP_W-1:0] dx_r, dx_nxt, dy_r, dy_nxt;
  logic [SMP_W-1:0] xs_r, xs_nxt;
  logic [DVD_W-1:0] prod_r, prod_nxt;
  logic             out_valid_r, out_valid_nxt;
  txas_out_t        out_data_r, out_data_nxt;

  logic [CNT_W-1:0] n_eff;
  logic [CNT_W-1:0] cnt_inc;
  logic             fire;
  logic [SMP_W-1:0] lo_sel, hi_sel, clamp_v, ys;
  logic             x_empty, y_empty;
  txas_div_req_t    div_req;
  txas_div_rsp_t    div_rsp;

  txas_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    n_eff   = (num_avg_r == '0) ? CNT_W'(1) : num_avg_r;
    cnt_inc = cnt_r + CNT_W'(1);
    fire    = (cnt_inc == '0) || (cnt_inc >= n_eff);
    x_empty = x_hi_r <= x_lo_r;
    y_empty = y_hi_r <= y_lo_r;

    lo_sel = (state_r == ST_MY_W) ? y_lo_r : x_lo_r;
    hi_sel = (state_r == ST_MY_W) ? y_hi_r : x_hi_r;
    if (div_rsp.quotient > DVD_W'(hi_sel)) begin
      clamp_v = hi_sel;
    end else if (div_rsp.quotient < DVD_W'(lo_sel)) begin
      clamp_v = lo_sel;
    end else begin
      clamp_v = div_rsp.quotient[SMP_W-1:0];
    end
    ys = y_empty ? '0 : div_rsp.quotient[SMP_W-1:0];

    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    x_sum_nxt     = x_sum_r;
    y_sum_nxt     = y_sum_r;
    dx_nxt        = dx_r;
    dy_nxt        = dy_r;
    xs_nxt        = xs_r;
    prod_nxt      = prod_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    div_req       = '0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          x_sum_nxt = x_sum_r + SUM_W'(in_data.x_raw);
          y_sum_nxt = y_sum_r + SUM_W'(in_data.y_raw);
          cnt_nxt   = cnt_inc;
          if (fire) begin
            state_nxt = ST_MX;
          end
        end
      end
      ST_MX: begin
        div_req.start    = 1'b1;
        div_req.dividend = DVD_W'(x_sum_r);
        div_req.divisor  = DVS_W'(n_eff);
        state_nxt        = ST_MX_W;
      end
      ST_MX_W: begin
        if (div_rsp.done) begin
          dx_nxt    = clamp_v - x_lo_r;
          state_nxt = ST_MY;
        end
      end
      ST_MY: begin
        div_req.start    = 1'b1;
        div_req.dividend = DVD_W'(y_sum_r);
        div_req.divisor  = DVS_W'(n_eff);
        state_nxt        = ST_MY_W;
      end
      ST_MY_W: begin
        if (div_rsp.done) begin
          dy_nxt    = clamp_v - y_lo_r;
          state_nxt = ST_MUL_X;
        end
      end
      ST_MUL_X: begin
        prod_nxt  = DVD_W'(dx_r) * DVD_W'(res_x_r);
        state_nxt = ST_SX;
      end
      ST_SX: begin
        div_req.start    = 1'b1;
        div_req.dividend = prod_r;
        div_req.divisor  = DVS_W'(x_hi_r - x_lo_r);
        state_nxt        = ST_SX_W;
      end
      ST_SX_W: begin
        if (div_rsp.done) begin
          xs_nxt    = x_empty ? '0 : div_rsp.quotient[SMP_W-1:0];
          state_nxt = ST_MUL_Y;
        end
      end
      ST_MUL_Y: begin
        prod_nxt  = DVD_W'(dy_r) * DVD_W'(res_y_r);
        state_nxt = ST_SY;
      end
      ST_SY: begin
        div_req.start    = 1'b1;
        div_req.dividend = prod_r;
        div_req.divisor  = DVS_W'(y_hi_r - y_lo_r);
        state_nxt        = ST_SY_W;
      end
      ST_SY_W: begin
        if (div_rsp.done) begin
          dy_nxt    = res_y_r - ys;
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt      = 1'b1;
          out_data_nxt.x_pos = xs_r;
          out_data_nxt.y_pos = dy_r;
          cnt_nxt            = '0;
          x_sum_nxt          = '0;
          y_sum_nxt          = '0;
          state_nxt          = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      x_sum_r     <= '0;
      y_sum_r     <= '0;
      out_valid_r <= 1'b0;
      num_avg_r   <= NUM_AVG_RST;
      x_lo_r      <= LIM_LO_RST;
      x_hi_r      <= LIM_HI_RST;
      y_lo_r      <= LIM_LO_RST;
      y_hi_r      <= LIM_HI_RST;
      res_x_r     <= RES_X_RST;
      res_y_r     <= RES_Y_RST;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      x_sum_r     <= x_sum_nxt;
      y_sum_r     <= y_sum_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        case (cfg_idx_t'(cfg_index))
          CFG_NUM_AVG:  num_avg_r <= cfg_data[CNT_W-1:0];
          CFG_X_LIM_LO: x_lo_r    <= cfg_data;
          CFG_X_LIM_HI: x_hi_r    <= cfg_data;
          CFG_Y_LIM_LO: y_lo_r    <= cfg_data;
          CFG_Y_LIM_HI: y_hi_r    <= cfg_data;
          CFG_RES_X:    res_x_r   <= cfg_data;
          CFG_RES_Y:    res_y_r   <= cfg_data;
          default: ;
        endcase
      end
    end
    dx_r       <= dx_nxt;
    dy_r       <= dy_nxt;
    xs_r       <= xs_nxt;
    prod_r     <= prod_nxt;
    out_data_r <= out_data_nxt;
  end

  // divider only runs while the sequencer is computing
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !div_rsp.busy)
    else $error("divider busy while sequencer idle");

  // accumulators are empty whenever no pair is counted
  a_sum_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && cnt_r == '0) |-> (x_sum_r == '0 && y_sum_r == '0))
    else $error("sums not cleared with count");

  // a result is loaded only after the final scale division
  a_load_order: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_OUT))
    else $error("result loaded outside output state");

  // the Y scale wait state only ends on a divider done pulse
  a_wait_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SY_W && state_nxt == ST_OUT) |-> div_rsp.done)
    else $error("scale result taken without divider done");

endmodule

>>> sim/tb.sv
// Self-checking testbench for touch_xy_average_and_scale: directed table, then random phases.
// Needs rtl/txas_pkg.sv and the block's RTL; has its own averaging and scaling predictor.
module tb;
  import txas_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES = 1000000;
  localparam int SETTLE_CYCLES = 150;
  localparam int HOLD_CYCLES = 400;
  localparam int N_DIR = 38;
  localparam int N_PHASES = 13;
  localparam int NAVG_PLAN [N_PHASES] = '{0, 1, 2, 3, 255, 64, 1, 4, 7, 16, 0, 128, 1};
  localparam int ITEMS_PLAN [N_PHASES] =
    '{100, 100, 100, 100, 520, 140, 100, 100, 100, 100, 100, 130, 60};

  typedef enum bit {ROW_CFG, ROW_SMP} row_kind_t;
  typedef struct {
    row_kind_t   kind;
    cfg_idx_t    idx;
    logic [11:0] a;
    logic [11:0] b;
    bit          typed;
    logic [11:0] ex;
    logic [11:0] ey;
  } row_t;

  // cfg rows: a = value; sample rows: a = x_raw, b = y_raw
  row_t directed_rows [N_DIR] = '{
    '{ROW_CFG, CFG_NUM_AVG,  12'd1,    12'd0,    1'b0, 12'd0,    12'd0},
    '{ROW_SMP, CFG_NUM_AVG,  12'd200,  12'd200,  1'b1, 12'd0,    12'd240},
    '{ROW_SMP, CFG_NUM_AVG,  12'd3900, 12'd3900, 1'b1, 12'd320,  12'd0},
    '{ROW_SMP, CFG_NUM_AVG,  12'd0,    12'd4095, 1'b1, 12'd0,    12'd0},
    '{ROW_SMP, CFG_NUM_AVG,  12'd4095, 12'd0,    1'b1, 12'd320,  12'd240},
    '{ROW_SMP, CFG_NUM_AVG,  12'd2050, 12'd2050, 1'b1, 12'd160,  12'd120},
    '{ROW_CFG, CFG_NUM_AVG,  12'd0,    12'd0,    1'b0, 12'd0,    12'd0},
    '{ROW_SMP, CFG_NUM_AVG,  12'd4095, 12'd4095, 1'b1, 12'd320,  12'd0},
    '{ROW_CFG, CFG_X_LIM_LO, 12'd0,    12'd0,    1'b0, 12'd0,    12'd0},
    '{ROW_CFG, CFG_X_LIM_HI, 12'd4095, 12'd0,    1'b0, 12'd0,    12'd0},
    '{ROW_CFG, CFG_Y_LIM_LO, 12'd0,    12'd0,    1'b0, 12'd0,    12'd0},
    '{ROW_CFG, CFG_Y_LIM_HI, 12'd4095, 12'd0,    1'b0, 12'd0,    12'd0},
    '{ROW_CFG, CFG_RES_X,    12'd4095, 12'd0,    1'b0, 12'd0,    12'd0},
    '{ROW_CFG, CFG_RES_Y,    12'd4095, 12'd0,    1'b0, 12'd0,    12'd0},
    '{ROW_SMP, CFG_NUM_AVG,  12'd0,    12'd4095, 1'b1, 12'd0,    12'd0},
    '{ROW_SMP, CFG_NUM_AVG,  12'd4095, 12'd0,    1'b1, 12'd4095, 12'd4095},
    '{ROW_SMP, CFG_NUM_AVG,  12'd2730, 12'd1365, 1'b1, 12'd2730, 12'd2730},
    '{ROW_CFG, CFG_X_LIM_HI, 12'd0,    12'd0,    1'b0, 12'd0,    12'd0},
    '{ROW_CFG, CFG_Y_LIM_LO, 12'd4095, 12'd0,    1'b0, 12'd0,    12'd0},
    '{ROW_CFG, CFG_Y_LIM_HI, 12'd0,    12'd0,    1'b0, 12'd0,    12'd0},
    '{ROW_SMP, CFG_NUM_AVG,  12'd1234, 12'd2345, 1'b1, 12'd0,    12'd4095},
    '{ROW_CFG, CFG_X_LIM_HI, 12'd4095, 12'd0,    1'b0, 12'd0,    12'd0},
    '{ROW_CFG, CFG_Y_LIM_LO, 12'd0,    12'd0,    1'b0, 12'd0,    12'd0},
    '{ROW_CFG, CFG_Y_LIM_HI, 12'd4095, 12'd0,    1'b0, 12'd0,    12'd0},
    '{ROW_CFG, CFG_RES_X,    12'd0,    12'd0,    1'b0, 12'd0,    12'd0},
    '{ROW_CFG, CFG_RES_Y,    12'd0,    12'd0,    1'b0, 12'd0,    12'd0},
    '{ROW_SMP, CFG_NUM_AVG,  12'd3000, 12'd1000, 1'b1, 12'd0,    12'd0},
    '{ROW_CFG, CFG_RES_X,    12'd4095, 12'd0,    1'b0, 12'd0,    12'd0},
    '{ROW_CFG, CFG_RES_Y,    12'd4095, 12'd0,    1'b0, 12'd0,    12'd0},
    '{ROW_CFG, CFG_NUM_AVG,  12'd2,    12'd0,    1'b0, 12'd0,    12'd0},
    '{ROW_SMP, CFG_NUM_AVG,  12'd1,    12'd1,    1'b0, 12'd0,    12'd0},
    '{ROW_SMP, CFG_NUM_AVG,  12'd2,    12'd2,    1'b1, 12'd1,    12'd4094},
    '{ROW_CFG, CFG_NUM_AVG,  12'd4,    12'd0,    1'b0, 12'd0,    12'd0},
    '{ROW_SMP, CFG_NUM_AVG,  12'd1000, 12'd1000, 1'b0, 12'd0,    12'd0},
    '{ROW_SMP, CFG_NUM_AVG,  12'd1000, 12'd1000, 1'b0, 12'd0,    12'd0},
    '{ROW_SMP, CFG_NUM_AVG,  12'd1000, 12'd1000, 1'b0, 12'd0,    12'd0},
    '{ROW_CFG, CFG_NUM_AVG,  12'd2,    12'd0,    1'b0, 12'd0,    12'd0},
    '{ROW_SMP, CFG_NUM_AVG,  12'd1000, 12'd1000, 1'b1, 12'd2000, 12'd2095}
  };

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  txas_in_t             in_data;
  logic                 out_valid;
  logic                 out_ready;
  txas_out_t            out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [SMP_W-1:0]     cfg_data;

  // predictor copy of the registers and accumulators
  logic [CNT_W-1:0] avg_n = NUM_AVG_RST;
  logic [SMP_W-1:0] xlo = LIM_LO_RST;
  logic [SMP_W-1:0] xhi = LIM_HI_RST;
  logic [SMP_W-1:0] ylo = LIM_LO_RST;
  logic [SMP_W-1:0] yhi = LIM_HI_RST;
  logic [SMP_W-1:0] rx = RES_X_RST;
  logic [SMP_W-1:0] ry = RES_Y_RST;
  logic [CNT_W-1:0] pair_cnt = '0;
  logic [SUM_W-1:0] xacc = '0;
  logic [SUM_W-1:0] yacc = '0;

  txas_out_t pending_pos [$];
  txas_out_t predicted;
  txas_out_t oldest;
  bit        produced;
  bit        beat_typed;
  txas_out_t beat_want;
  bit        free_run = 1'b0;
  bit        hold_pending = 1'b0;
  int        cycle_count = 0;
  int        mismatches = 0;
  int        pairs_sent = 0;
  int        positions_checked = 0;
  int        reg_writes = 0;

  touch_xy_average_and_scale dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic logic [SMP_W-1:0] scale_to_screen(longint v, longint lo, longint hi,
                                                       longint res);
    if (hi <= lo) return '0;
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return SMP_W'(((v - lo) * res) / (hi - lo));
  endfunction

  function automatic bit accumulate_pair(input txas_in_t s, output txas_out_t r);
    longint n;
    n = (avg_n == '0) ? longint'(1) : longint'(avg_n);
    r = '0;
    xacc = xacc + SUM_W'(s.x_raw);
    yacc = yacc + SUM_W'(s.y_raw);
    pair_cnt = pair_cnt + CNT_W'(1);
    if (pair_cnt != '0 && longint'(pair_cnt) < n) return 1'b0;
    r.x_pos = scale_to_screen(longint'(xacc) / n, longint'(xlo), longint'(xhi),
                              longint'(rx));
    r.y_pos = ry - scale_to_screen(longint'(yacc) / n, longint'(ylo), longint'(yhi),
                                   longint'(ry));
    pair_cnt = '0;
    xacc = '0;
    yacc = '0;
    return 1'b1;
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [SMP_W-1:0] val);
    case (cfg_idx_t'(idx))
      CFG_NUM_AVG:  avg_n = val[CNT_W-1:0];
      CFG_X_LIM_LO: xlo = val;
      CFG_X_LIM_HI: xhi = val;
      CFG_Y_LIM_LO: ylo = val;
      CFG_Y_LIM_HI: yhi = val;
      CFG_RES_X:    rx = val;
      CFG_RES_Y:    ry = val;
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < 50) $display("MISMATCH cycle %0d: %s", cycle_count, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles, %0d positions outstanding",
               cycle_count, pending_pos.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // checks results against the oldest expectation, then predicts from new beats
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        positions_checked++;
        if (pending_pos.size() == 0) begin
          report_mismatch($sformatf("unexpected position x=%0d y=%0d",
                                    out_data.x_pos, out_data.y_pos));
        end else begin
          oldest = pending_pos.pop_front();
          if (out_data.x_pos !== oldest.x_pos)
            report_mismatch($sformatf("x_pos got %0d expected %0d",
                                      out_data.x_pos, oldest.x_pos));
          if (out_data.y_pos !== oldest.y_pos)
            report_mismatch($sformatf("y_pos got %0d expected %0d",
                                      out_data.y_pos, oldest.y_pos));
        end
      end
      if (cfg_valid && cfg_ready) begin
        apply_reg(cfg_index, cfg_data);
        reg_writes++;
      end
      if (in_valid && in_ready) begin
        pairs_sent++;
        produced = accumulate_pair(in_data, predicted);
        if (beat_typed) pending_pos.push_back(beat_want);
        else if (produced) pending_pos.push_back(predicted);
      end
    end
  end

  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst_n) begin
        out_ready <= 1'b0;
      end else if (hold_pending) begin
        hold_pending <= 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ready <= free_run || ($urandom_range(99) >= 7);
      end
    end
  end

  task automatic send_pair(input logic [SMP_W-1:0] x, input logic [SMP_W-1:0] y,
                           input bit typed, input txas_out_t want);
    txas_in_t s;
    s.x_raw = x;
    s.y_raw = y;
    while (!free_run && $urandom_range(99) < 7) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= s;
    beat_typed <= typed;
    beat_want <= want;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [SMP_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_pos.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [SMP_W-1:0] near_point(int c);
    int v;
    v = c + int'($urandom_range(64)) - 32;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return SMP_W'(v);
  endfunction

  initial begin
    int ph;
    int k;
    int cx;
    int cy;
    logic [SMP_W-1:0] xl, xh, yl, yh, rxv, ryv, sx, sy;
    txas_out_t want;

    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_NUM_AVG;
    cfg_data <= '0;
    beat_typed <= 1'b0;
    beat_want <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < N_DIR; r++) begin
      if (directed_rows[r].kind == ROW_CFG) begin
        if (r > 0 && directed_rows[r-1].kind == ROW_SMP) drain_results();
        write_reg(directed_rows[r].idx, directed_rows[r].a);
      end else begin
        want.x_pos = directed_rows[r].ex;
        want.y_pos = directed_rows[r].ey;
        send_pair(directed_rows[r].a, directed_rows[r].b, directed_rows[r].typed, want);
      end
    end

    want = '0;
    for (ph = 0; ph < N_PHASES; ph++) begin
      drain_results();
      free_run <= (ph == 6);
      if (ph == 5) begin
        xl = LIM_LO_RST; xh = LIM_HI_RST; yl = LIM_LO_RST; yh = LIM_HI_RST;
        rxv = RES_X_RST; ryv = RES_Y_RST;
      end else if (ph % 4 == 0) begin
        xl = '0; xh = 12'd4095; yl = '0; yh = 12'd4095;
        rxv = 12'd4095; ryv = 12'd4095;
      end else begin
        xl = SMP_W'($urandom_range(800));
        xh = SMP_W'($urandom_range(4095, 3000));
        yl = SMP_W'($urandom_range(800));
        yh = SMP_W'($urandom_range(4095, 3000));
        rxv = SMP_W'($urandom_range(4095));
        ryv = SMP_W'($urandom_range(4095));
        if (ph % 4 == 1) begin
          if ($urandom_range(1)) begin
            xh = SMP_W'($urandom_range(4095));
            xl = SMP_W'($urandom_range(4095, xh));
          end else begin
            yh = SMP_W'($urandom_range(4095));
            yl = SMP_W'($urandom_range(4095, yh));
          end
        end
      end
      write_reg(CFG_NUM_AVG, SMP_W'(NAVG_PLAN[ph]));
      write_reg(CFG_X_LIM_LO, xl);
      write_reg(CFG_X_LIM_HI, xh);
      write_reg(CFG_Y_LIM_LO, yl);
      write_reg(CFG_Y_LIM_HI, yh);
      write_reg(CFG_RES_X, rxv);
      write_reg(CFG_RES_Y, ryv);
      cx = int'($urandom_range(4095));
      cy = int'($urandom_range(4095));
      for (k = 0; k < ITEMS_PLAN[ph]; k++) begin
        if (ph == 0 && k == 20) hold_pending <= 1'b1;
        if (ph == 1 && k == 50) drain_results();
        if ($urandom_range(39) == 0) begin
          cx = int'($urandom_range(4095));
          cy = int'($urandom_range(4095));
        end
        if ($urandom_range(99) < 80) begin
          sx = near_point(cx);
          sy = near_point(cy);
        end else begin
          sx = SMP_W'($urandom_range(4095));
          sy = SMP_W'($urandom_range(4095));
        end
        send_pair(sx, sy, 1'b0, want);
      end
    end
    free_run <= 1'b0;
    drain_results();

    $display("Covered %0d sample beats, %0d position beats checked, %0d register writes,",
             pairs_sent, positions_checked, reg_writes);
    $display("over pair counts 0 to 255, full, empty and reset windows, and output stalls.");
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
